// File: rtl/wph_pkg.sv
`timescale 1ns / 1ps

package wph_pkg;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ERR_NONE     = 4'd0,
        ERR_NOT_RIFF = 4'd1,
        ERR_NOT_WAVE = 4'd2,
        ERR_NO_FMT   = 4'd3,
        ERR_FMT_SIZE = 4'd4,
        ERR_NOT_PCM  = 4'd5,
        ERR_CHANNELS = 4'd6,
        ERR_NOT_16   = 4'd7,
        ERR_NO_DATA  = 4'd8
    } err_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2,
        PH_STOP   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       start_of_file;
    } in_t;

    typedef struct packed {
        kind_t              kind;
        err_t               error_code;
        logic signed [15:0] sample;
        logic [1:0]         channels;
        logic [31:0]        sample_rate;
        logic [31:0]        byte_rate;
        logic [15:0]        block_align;
        logic [31:0]        data_bytes;
        logic               last;
    } out_t;

    localparam logic [31:0] TAG_RIFF     = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE     = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT      = 32'h666D_7420;
    localparam logic [31:0] FMT_SIZE_PCM = 32'h0000_0010;
    localparam logic [15:0] FORMAT_PCM   = 16'h0001;
    localparam logic [15:0] MAX_CHANNELS = 16'h0002;
    localparam logic [15:0] BITS_16      = 16'h0010;
    localparam logic [31:0] TAG_DATA     = 32'h6461_7461;

endpackage

// File: rtl/wav_pcm16_header_parser_core.sv
`timescale 1ns / 1ps
// channel   direction  payload  handshake
// s_        in         in_t     s_valid / s_ready
// m_        out        out_t    m_valid / m_ready
//
// one byte per cycle while s_ready is high; each transfer is parsed in the cycle it is taken
// the result of a transfer is registered in the output buffer, in main or, if main is held, in spare
// a two-entry output buffer keeps s_ready high while one result waits
// aresetn is synchronous, active low; the parser idles until start_of_file

module wav_pcm16_header_parser_core
    import wph_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic in_fire;
    logic res_valid;
    out_t res_data;

    assign in_fire = s_valid && s_ready;

    wph_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_data   (s_data),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    wph_skid u_skid (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (res_valid),
        .push_data  (res_data),
        .push_ready (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// File: rtl/wph_parser.sv
`timescale 1ns / 1ps

module wph_parser
    import wph_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_fire,
    input  in_t  in_data,
    output logic res_valid,
    output out_t res_data
);

    localparam logic [5:0] POS_RIFF   = 6'd3;
    localparam logic [5:0] POS_WAVE   = 6'd11;
    localparam logic [5:0] POS_FMT    = 6'd15;
    localparam logic [5:0] POS_FSIZE  = 6'd19;
    localparam logic [5:0] POS_FORMAT = 6'd21;
    localparam logic [5:0] POS_CHAN   = 6'd23;
    localparam logic [5:0] POS_RATE   = 6'd27;
    localparam logic [5:0] POS_BRATE  = 6'd31;
    localparam logic [5:0] POS_ALIGN  = 6'd33;
    localparam logic [5:0] POS_BITS   = 6'd35;
    localparam logic [5:0] POS_DATA   = 6'd39;
    localparam logic [5:0] POS_SIZE   = 6'd43;

    phase_t      phase_reg, phase_next;
    logic [5:0]  pos_reg, pos_next;
    logic [31:0] acc_reg, acc_next;
    logic [1:0]  chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] brate_reg, brate_next;
    logic [15:0] align_reg, align_next;
    logic [30:0] left_reg, left_next;
    logic [7:0]  low_reg, low_next;
    logic        odd_reg, odd_next;

    phase_t      phase_cur;
    logic [5:0]  pos_cur;
    logic        big;
    logic [7:0]  b;
    err_t        err;
    logic        hdr_done;
    logic        smp_done;
    logic [30:0] left_dec;

    assign b         = in_data.byte_value;
    assign phase_cur = in_data.start_of_file ? PH_HEADER : phase_reg;
    assign pos_cur   = in_data.start_of_file ? 6'd0 : pos_reg;
    assign big       = (pos_cur < 6'd4) || (pos_cur >= 6'd8 && pos_cur < 6'd16)
                    || (pos_cur >= 6'd36 && pos_cur < 6'd40);
    assign left_dec  = left_reg - 31'd1;

    // field assembly, header checks and sample byte pairing
    always_comb begin
        acc_next   = acc_reg;
        pos_next   = pos_reg;
        chan_next  = chan_reg;
        rate_next  = rate_reg;
        brate_next = brate_reg;
        align_next = align_reg;
        left_next  = left_reg;
        low_next   = low_reg;
        odd_next   = odd_reg;
        err        = ERR_NONE;
        hdr_done   = 1'b0;
        smp_done   = 1'b0;
        if (in_fire) begin
            if (in_data.start_of_file) begin
                odd_next  = 1'b0;
                left_next = '0;
            end
            case (phase_cur)
                PH_HEADER: begin
                    acc_next = big ? {acc_reg[23:0], b} : {b, acc_reg[31:8]};
                    pos_next = pos_cur + 6'd1;
                    case (pos_cur)
                        POS_RIFF:   if (acc_next != TAG_RIFF) err = ERR_NOT_RIFF;
                        POS_WAVE:   if (acc_next != TAG_WAVE) err = ERR_NOT_WAVE;
                        POS_FMT:    if (acc_next != TAG_FMT) err = ERR_NO_FMT;
                        POS_FSIZE:  if (acc_next != FMT_SIZE_PCM) err = ERR_FMT_SIZE;
                        POS_FORMAT: if (acc_next[31:16] != FORMAT_PCM) err = ERR_NOT_PCM;
                        POS_CHAN: begin
                            if (acc_next[31:16] > MAX_CHANNELS) err = ERR_CHANNELS;
                            else chan_next = acc_next[17:16];
                        end
                        POS_RATE:   rate_next = acc_next;
                        POS_BRATE:  brate_next = acc_next;
                        POS_ALIGN:  align_next = acc_next[31:16];
                        POS_BITS:   if (acc_next[31:16] != BITS_16) err = ERR_NOT_16;
                        POS_DATA:   if (acc_next != TAG_DATA) err = ERR_NO_DATA;
                        POS_SIZE: begin
                            hdr_done  = 1'b1;
                            left_next = acc_next[31:1];
                            odd_next  = 1'b0;
                        end
                        default: ;
                    endcase
                end
                PH_DATA: begin
                    if (!odd_reg) begin
                        low_next = b;
                        odd_next = 1'b1;
                    end else begin
                        odd_next  = 1'b0;
                        left_next = left_dec;
                        smp_done  = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // phase
    always_comb begin
        phase_next = phase_reg;
        if (in_fire) begin
            phase_next = phase_cur;
            if (err != ERR_NONE) begin
                phase_next = PH_STOP;
            end else if (hdr_done) begin
                phase_next = (left_next == '0) ? PH_STOP : PH_DATA;
            end else if (smp_done && left_next == '0) begin
                phase_next = PH_STOP;
            end
        end
    end

    // result
    always_comb begin
        res_valid = hdr_done || smp_done || (err != ERR_NONE);
        res_data  = '0;
        if (err != ERR_NONE) begin
            res_data.kind       = KIND_ERROR;
            res_data.error_code = err;
        end else if (hdr_done) begin
            res_data.kind        = KIND_HEADER;
            res_data.channels    = chan_reg;
            res_data.sample_rate = rate_reg;
            res_data.byte_rate   = brate_reg;
            res_data.block_align = align_reg;
            res_data.data_bytes  = acc_next;
            res_data.last        = (left_next == '0);
        end else begin
            res_data.kind   = KIND_SAMPLE;
            res_data.sample = {b, low_reg};
            res_data.last   = smp_done && (left_next == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            acc_reg   <= '0;
            chan_reg  <= '0;
            rate_reg  <= '0;
            brate_reg <= '0;
            align_reg <= '0;
            left_reg  <= '0;
            low_reg   <= '0;
            odd_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            chan_reg  <= chan_next;
            rate_reg  <= rate_next;
            brate_reg <= brate_next;
            align_reg <= align_next;
            left_reg  <= left_next;
            low_reg   <= low_next;
            odd_reg   <= odd_next;
        end
    end

endmodule

// File: rtl/wph_skid.sv
`timescale 1ns / 1ps

module wph_skid
    import wph_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  out_t push_data,
    output logic push_ready,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic main_valid_reg;
    logic spare_valid_reg;
    out_t main_reg;
    out_t spare_reg;

    assign push_ready = !spare_valid_reg;
    assign m_valid    = main_valid_reg;
    assign m_data     = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else if (!main_valid_reg || m_ready) begin
            if (spare_valid_reg) begin
                main_valid_reg  <= 1'b1;
                spare_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= push;
            end
        end else if (push) begin
            spare_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!main_valid_reg || m_ready) begin
            main_reg <= spare_valid_reg ? spare_reg : push_data;
        end else if (push) begin
            spare_reg <= push_data;
        end
    end

endmodule

// File: dv/wav_pcm16_header_parser_core_tb.sv
`timescale 1ns / 1ps

module wav_pcm16_header_parser_core_tb;
    import wph_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_TAIL  = 150;
    localparam int BYTE_TARGET = 1450;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    in_t  wav_bytes_q[$];
    out_t parsed_q[$];

    // parser state as seen from outside
    phase_t      ph;
    logic [5:0]  hdr_pos;
    logic [31:0] acc;
    logic [1:0]  chans;
    logic [31:0] rate;
    logic [31:0] brate;
    logic [15:0] align;
    logic [30:0] samples_remaining;
    logic [7:0]  lo_byte;
    logic        have_lo;

    int   bytes_queued  = 0;
    int   bytes_taken   = 0;
    int   results_seen  = 0;
    int   headers_seen  = 0;
    int   errors_seen   = 0;
    int   samples_seen  = 0;
    int   lasts_seen    = 0;
    int   mismatches    = 0;
    int   idle_cycles   = 0;
    int   src_gap       = 0;
    int   sink_gap      = 0;
    logic quiet         = 1'b0;
    logic hold_rx       = 1'b0;
    out_t want;

    wav_pcm16_header_parser_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void clear_parse_state();
        hdr_pos           = '0;
        acc               = '0;
        chans             = '0;
        rate              = '0;
        brate             = '0;
        align             = '0;
        samples_remaining = '0;
        lo_byte           = '0;
        have_lo           = 1'b0;
    endfunction

    function automatic void parse_byte(in_t item);
        logic [5:0] pos;
        logic       big;
        err_t       err;
        out_t       r;
        err = ERR_NONE;
        r   = '0;
        if (item.start_of_file) begin
            clear_parse_state();
            ph = PH_HEADER;
        end
        if (ph == PH_IDLE || ph == PH_STOP) return;
        if (ph == PH_DATA) begin
            if (!have_lo) begin
                lo_byte = item.byte_value;
                have_lo = 1'b1;
                return;
            end
            have_lo = 1'b0;
            samples_remaining = samples_remaining - 31'd1;
            r.kind   = KIND_SAMPLE;
            r.sample = {item.byte_value, lo_byte};
            if (samples_remaining == '0) begin
                r.last = 1'b1;
                ph     = PH_STOP;
            end
            parsed_q.push_back(r);
            return;
        end
        // header bytes: tags big-endian, numbers little-endian
        pos = hdr_pos;
        big = pos < 6'd4 || (pos >= 6'd8 && pos < 6'd16) || (pos >= 6'd36 && pos < 6'd40);
        acc = big ? {acc[23:0], item.byte_value} : {item.byte_value, acc[31:8]};
        hdr_pos = pos + 6'd1;
        case (pos)
            6'd3:  if (acc != TAG_RIFF) err = ERR_NOT_RIFF;
            6'd11: if (acc != TAG_WAVE) err = ERR_NOT_WAVE;
            6'd15: if (acc != TAG_FMT) err = ERR_NO_FMT;
            6'd19: if (acc != FMT_SIZE_PCM) err = ERR_FMT_SIZE;
            6'd21: if (acc[31:16] != FORMAT_PCM) err = ERR_NOT_PCM;
            6'd23: begin
                if (acc[31:16] > MAX_CHANNELS) err = ERR_CHANNELS;
                else chans = acc[17:16];
            end
            6'd27: rate = acc;
            6'd31: brate = acc;
            6'd33: align = acc[31:16];
            6'd35: if (acc[31:16] != BITS_16) err = ERR_NOT_16;
            6'd39: if (acc != TAG_DATA) err = ERR_NO_DATA;
            6'd43: begin
                samples_remaining = acc[31:1];
                have_lo           = 1'b0;
                r.kind        = KIND_HEADER;
                r.channels    = chans;
                r.sample_rate = rate;
                r.byte_rate   = brate;
                r.block_align = align;
                r.data_bytes  = acc;
                if (acc[31:1] == '0) begin
                    r.last = 1'b1;
                    ph     = PH_STOP;
                end else begin
                    ph = PH_DATA;
                end
                parsed_q.push_back(r);
                return;
            end
            default: ;
        endcase
        if (err != ERR_NONE) begin
            r.kind       = KIND_ERROR;
            r.error_code = err;
            ph           = PH_STOP;
            parsed_q.push_back(r);
        end
    endfunction

    function automatic string fmt_record(out_t r);
        return $sformatf({"kind=%0d err=%0d sample=%0d ch=%0d rate=%h brate=%h",
                          " align=%h bytes=%h last=%b"},
                         r.kind, r.error_code, r.sample, r.channels, r.sample_rate,
                         r.byte_rate, r.block_align, r.data_bytes, r.last);
    endfunction

    task automatic push_byte(logic [7:0] b, logic sof);
        in_t it;
        it.byte_value    = b;
        it.start_of_file = sof;
        wav_bytes_q.push_back(it);
        bytes_queued++;
    endtask

    // one file: header, optional corrupted byte, optional early cut, then payload bytes
    task automatic queue_wav(logic [15:0] nch, logic [31:0] srate, logic [31:0] dsize,
                             int payload, int bad_pos = -1, logic [7:0] bad_val = 8'h00,
                             int hdr_len = 44, int fill = -1);
        logic [7:0] hdr [44];
        {hdr[0], hdr[1], hdr[2], hdr[3]}     = TAG_RIFF;
        {hdr[7], hdr[6], hdr[5], hdr[4]}     = (fill < 0) ? $urandom : {4{fill[7:0]}};
        {hdr[8], hdr[9], hdr[10], hdr[11]}   = TAG_WAVE;
        {hdr[12], hdr[13], hdr[14], hdr[15]} = TAG_FMT;
        {hdr[19], hdr[18], hdr[17], hdr[16]} = FMT_SIZE_PCM;
        {hdr[21], hdr[20]}                   = FORMAT_PCM;
        {hdr[23], hdr[22]}                   = nch;
        {hdr[27], hdr[26], hdr[25], hdr[24]} = srate;
        {hdr[31], hdr[30], hdr[29], hdr[28]} = (fill < 0) ? $urandom : {4{fill[7:0]}};
        {hdr[33], hdr[32]}                   = (fill < 0) ? 16'($urandom) : {2{fill[7:0]}};
        {hdr[35], hdr[34]}                   = BITS_16;
        {hdr[36], hdr[37], hdr[38], hdr[39]} = TAG_DATA;
        {hdr[43], hdr[42], hdr[41], hdr[40]} = dsize;
        for (int i = 0; i < hdr_len; i++) begin
            push_byte((i == bad_pos) ? bad_val : hdr[i], i == 0);
        end
        for (int j = 0; j < payload; j++) begin
            push_byte(8'($urandom), 1'b0);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (src_gap > 0) begin
                src_gap = src_gap - 1;
                s_valid <= 1'b0;
            end else if (wav_bytes_q.size() != 0) begin
                s_data  <= wav_bytes_q.pop_front();
                s_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 19) == 0) src_gap = $urandom_range(1, 12);
            end else begin
                s_valid <= 1'b0;
            end
            quiet <= wav_bytes_q.size() < QUIET_TAIL;
        end
    end

    // result sink
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (sink_gap > 0) sink_gap = sink_gap - 1;
            else if (!quiet && $urandom_range(0, 15) == 0) sink_gap = $urandom_range(1, 12);
            m_ready <= !hold_rx && sink_gap == 0;
        end
    end

    // long receiver hold-off so the output buffer fills and s_ready drops
    initial begin
        while (results_seen < 40) @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        if (!aresetn) begin
            ph = PH_IDLE;
            clear_parse_state();
            parsed_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                case (m_data.kind)
                    KIND_HEADER: headers_seen++;
                    KIND_ERROR:  errors_seen++;
                    default:     samples_seen++;
                endcase
                if (m_data.last === 1'b1) lasts_seen++;
                if (parsed_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: %s", fmt_record(m_data));
                end else begin
                    want = parsed_q.pop_front();
                    if (m_data.kind !== want.kind || m_data.error_code !== want.error_code ||
                        m_data.sample !== want.sample || m_data.channels !== want.channels ||
                        m_data.sample_rate !== want.sample_rate ||
                        m_data.byte_rate !== want.byte_rate ||
                        m_data.block_align !== want.block_align ||
                        m_data.data_bytes !== want.data_bytes || m_data.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d mismatch", results_seen);
                            $display("  expected %s", fmt_record(want));
                            $display("  actual   %s", fmt_record(m_data));
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                bytes_taken++;
                parse_byte(s_data);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout with %0d results outstanding", parsed_q.size());
                $display("wav_pcm16_header_parser_core test failed");
                $finish;
            end
        end
    end

    initial begin
        int          pick;
        int          payload;
        int          vary;
        logic [15:0] nch;
        logic [31:0] dsize;

        // bytes before any start are dropped
        repeat (5) push_byte(8'($urandom), 1'b0);
        queue_wav(16'd1, 32'd44100, 32'd4, 4);
        queue_wav(16'd2, 32'd48000, 32'd0, 3);
        queue_wav(16'd1, 32'd8000, 32'd1, 2);
        queue_wav(16'd0, 32'd22050, 32'd5, 7);
        queue_wav(16'd2, 32'hFFFF_FFFF, 32'd2, 2, -1, 8'h00, 44, 255);
        queue_wav(16'd0, 32'd0, 32'd2, 2, -1, 8'h00, 44, 0);
        // sample extremes
        queue_wav(16'd1, 32'd16000, 32'd8, 0);
        push_byte(8'h00, 1'b0); push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'h7F, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
        // every check failing, trailing bytes ignored
        queue_wav(16'd1, 32'd8000, 32'd4, 4, 0, 8'h00);
        queue_wav(16'd1, 32'd8000, 32'd4, 4, 3, 8'h47);
        queue_wav(16'd1, 32'd8000, 32'd4, 4, 8, 8'h77);
        queue_wav(16'd1, 32'd8000, 32'd4, 4, 15, 8'h00);
        queue_wav(16'd1, 32'd8000, 32'd4, 4, 16, 8'h12);
        queue_wav(16'd1, 32'd8000, 32'd4, 4, 20, 8'h03);
        queue_wav(16'd3, 32'd8000, 32'd4, 4);
        queue_wav(16'hFFFF, 32'd8000, 32'd4, 4);
        queue_wav(16'h0100, 32'd8000, 32'd4, 4);
        queue_wav(16'd1, 32'd8000, 32'd4, 4, 34, 8'h08);
        queue_wav(16'd1, 32'd8000, 32'd4, 4, 39, 8'h62);
        // restarts in mid-header and mid-data
        queue_wav(16'd1, 32'd8000, 32'd4, 4, -1, 8'h00, 20);
        queue_wav(16'd2, 32'd48000, 32'hFFFF_FFFF, 7);
        queue_wav(16'd2, 32'd96000, 32'hFFFF_FFFE, 5);

        while (bytes_queued < BYTE_TARGET) begin
            pick  = $urandom_range(0, 99);
            nch   = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
            dsize = ($urandom_range(0, 24) == 0) ? $urandom : $urandom_range(0, 48);
            payload = (dsize < 64) ? int'(dsize) : $urandom_range(0, 20);
            vary    = $urandom_range(0, 9);
            if (vary == 0) payload = payload + $urandom_range(1, 5);
            else if (vary == 1) payload = $urandom_range(0, payload);
            if (pick < 75)
                queue_wav(nch, $urandom, dsize, payload);
            else if (pick < 88)
                queue_wav(nch, $urandom, dsize, payload, $urandom_range(0, 43), 8'($urandom));
            else if (pick < 95)
                queue_wav(nch, $urandom, dsize, payload, -1, 8'h00, $urandom_range(1, 43));
            else
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom), 1'b0);
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        wait (wav_bytes_q.size() == 0);
        @(posedge aclk);
        while (s_valid) @(posedge aclk);
        while (parsed_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("sent %0d bytes; checked %0d results: %0d headers, %0d errors, %0d samples",
                 bytes_taken, results_seen, headers_seen, errors_seen, samples_seen);
        $display("%0d results flagged last, %0d mismatches", lasts_seen, mismatches);
        if (mismatches == 0) begin
            $display("wav_pcm16_header_parser_core test passed");
        end else begin
            $display("wav_pcm16_header_parser_core test failed");
        end
        $finish;
    end

endmodule
